// File: hw/rtl/cfp_pkg.sv
// shared types and constants for the crc-checked sensor frame parser
package cfp_pkg;

   localparam int FRAME_BYTES = 39;
   localparam int CRC_POS     = FRAME_BYTES - 2;
   localparam int STORE_BYTES = FRAME_BYTES - 3;
   localparam int STORE_BITS  = STORE_BYTES * 8;
   localparam int POS_W       = 6;

   localparam logic [7:0] CRC_POLY = 8'h07;

   localparam logic [7:0] START_MARKER_RESET = 8'h58;
   localparam logic [7:0] END_MARKER_RESET   = 8'h0a;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_MARKER   = 1'b1;

   localparam int RSP_DATA_W = 296;

   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      BAD_LENGTH   = 3'd1,
      BAD_START    = 3'd2,
      BAD_END      = 3'd3,
      CRC_MISMATCH = 3'd4
   } status_type;

   typedef struct packed {
      logic [31:0] temperature_bits;
      logic [31:0] gyro_z_bits;
      logic [31:0] gyro_y_bits;
      logic [31:0] gyro_x_bits;
      logic [31:0] accel_z_bits;
      logic [31:0] accel_y_bits;
      logic [31:0] accel_x_bits;
      logic [31:0] milliseconds;
      logic [31:0] seconds;
      status_type  status;
   } result_type;

endpackage

// File: hw/rtl/crc8_checked_sensor_frame_parser.sv
// top level of the crc-8 checked fixed-length sensor frame parser
// Usage:
//   req_* carries one frame byte per request (tdata[7:0]); req_tlast marks the
//   frame's last byte. Byte requests are taken while req_tready is high, so
//   frames of 39 bytes stream in with no gaps needed between frames.
//   rsp_* gives one result per request with tlast set: status and nine 32-bit
//   words, registered in the output register, or in the skid entry while rsp_tready is low.
//   Status order: bad length, bad start, bad end, crc mismatch; a failed frame
//   returns all data words as zero.
//   csr_* writes the start marker (index 0) and end marker (index 1).
//   Throughput: one byte per cycle while req_tready is high.
//   Stall: the result register has a one-entry skid behind it; req_tready falls
//   only while that skid entry is occupied, and rises once rsp_tready drains it.
//   Reset: frame position, crc and flags clear, markers return to 'X' and
//   newline, and both result entries empty.
module crc8_checked_sensor_frame_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] rx_byte
   input  logic                             req_tlast,  // frame_end
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] status, [34:3] seconds, [66:35] milliseconds, [98:67] accel_x_bits,
   // [130:99] accel_y_bits, [162:131] accel_z_bits, [194:163] gyro_x_bits,
   // [226:195] gyro_y_bits, [258:227] gyro_z_bits, [290:259] temperature_bits,
   // [295:291] zero
   output logic [cfp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [cfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_wdata
);
   import cfp_pkg::*;

   logic [7:0] start_marker_ff, start_marker_in;
   logic [7:0] end_marker_ff, end_marker_in;
   logic       accept;
   logic       res_valid;
   result_type res;
   result_type rsp_res;

   always_comb begin
      start_marker_in = start_marker_ff;
      end_marker_in   = end_marker_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_in = csr_wdata;
            CSR_END_MARKER:   end_marker_in   = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
      end else begin
         start_marker_ff <= start_marker_in;
         end_marker_ff   <= end_marker_in;
      end
   end

   assign accept = req_tvalid && req_tready;

   cfp_frame_acc u_frame_acc (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_tdata),
      .frame_end    (req_tlast),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   cfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   assign rsp_tdata = {5'b0,
                       rsp_res.temperature_bits,
                       rsp_res.gyro_z_bits,
                       rsp_res.gyro_y_bits,
                       rsp_res.gyro_x_bits,
                       rsp_res.accel_z_bits,
                       rsp_res.accel_y_bits,
                       rsp_res.accel_x_bits,
                       rsp_res.milliseconds,
                       rsp_res.seconds,
                       rsp_res.status};

endmodule

// File: hw/rtl/cfp_frame_acc.sv
// per-byte frame state: position, crc-8, markers check and payload shift line
module cfp_frame_acc (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   input  logic                frame_end,
   input  logic [7:0]          start_marker,
   input  logic [7:0]          end_marker,
   output logic                res_valid,
   output cfp_pkg::result_type res
);
   import cfp_pkg::*;

   logic [POS_W-1:0]      byte_position_ff, byte_position_in, pos_inc;
   logic [7:0]            running_crc_ff, running_crc_in;
   logic                  start_seen_ok_ff, start_seen_ok_in;
   logic [7:0]            received_crc_ff, received_crc_in;
   logic [STORE_BITS-1:0] store_ff, store_in;
   status_type            status;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // count saturates one past the frame length
   always_comb begin
      if (byte_position_ff <= POS_W'(FRAME_BYTES)) begin
         pos_inc = byte_position_ff + POS_W'(1);
      end else begin
         pos_inc = byte_position_ff;
      end
   end

   always_comb begin
      byte_position_in = byte_position_ff;
      running_crc_in   = running_crc_ff;
      start_seen_ok_in = start_seen_ok_ff;
      received_crc_in  = received_crc_ff;
      store_in         = store_ff;
      if (accept) begin
         if (byte_position_ff == '0) begin
            start_seen_ok_in = (rx_byte == start_marker);
         end
         if (byte_position_ff < POS_W'(CRC_POS)) begin
            running_crc_in = crc8_update(running_crc_ff, rx_byte);
            if (byte_position_ff != '0) begin
               // payload bytes shift down so byte 1 ends at the bottom
               store_in = {rx_byte, store_ff[STORE_BITS-1:8]};
            end
         end else if (byte_position_ff == POS_W'(CRC_POS)) begin
            received_crc_in = rx_byte;
         end
         byte_position_in = pos_inc;
         if (frame_end) begin
            byte_position_in = '0;
            running_crc_in   = '0;
            start_seen_ok_in = 1'b0;
            received_crc_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         running_crc_ff   <= '0;
         start_seen_ok_ff <= 1'b0;
         received_crc_ff  <= '0;
      end else begin
         byte_position_ff <= byte_position_in;
         running_crc_ff   <= running_crc_in;
         start_seen_ok_ff <= start_seen_ok_in;
         received_crc_ff  <= received_crc_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   // crc and start flag are complete once the last byte sits at the final position
   always_comb begin
      priority if (pos_inc != POS_W'(FRAME_BYTES)) begin
         status = BAD_LENGTH;
      end else if (!start_seen_ok_ff) begin
         status = BAD_START;
      end else if (rx_byte != end_marker) begin
         status = BAD_END;
      end else if (running_crc_ff != received_crc_ff) begin
         status = CRC_MISMATCH;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      res        = '0;
      res.status = status;
      if (status == STATUS_OK) begin
         res.seconds          = store_ff[0   +: 32];
         res.milliseconds     = store_ff[32  +: 32];
         res.accel_x_bits     = store_ff[64  +: 32];
         res.accel_y_bits     = store_ff[96  +: 32];
         res.accel_z_bits     = store_ff[128 +: 32];
         res.gyro_x_bits      = store_ff[160 +: 32];
         res.gyro_y_bits      = store_ff[192 +: 32];
         res.gyro_z_bits      = store_ff[224 +: 32];
         res.temperature_bits = store_ff[256 +: 32];
      end
   end

   assign res_valid = accept && frame_end;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      byte_position_ff <= POS_W'(FRAME_BYTES + 1))
      else $error("byte position beyond saturation");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> byte_position_ff == '0 && running_crc_ff == '0
                              && !start_seen_ok_ff)
      else $error("frame state not cleared after last byte");

   a_ok_needs_full: assert property (@(posedge clock) disable iff (reset)
      res_valid && status == STATUS_OK |-> byte_position_ff == POS_W'(FRAME_BYTES - 1)
                                           && start_seen_ok_ff)
      else $error("good status without a complete frame");

endmodule

// File: hw/rtl/cfp_out_buf.sv
// result register with a skid entry that holds one further result while the receiver stalls
module cfp_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  cfp_pkg::result_type in_data,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output cfp_pkg::result_type out_data
);
   import cfp_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("result arrived with both entries full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry not moved to output");

endmodule
